// ===== sv/hsv2rgb_pkg.sv =====
// Shared types for the HSV to RGB converter pipeline.
// No dependencies; imported by every module of the block.
package hsv2rgb_pkg;

  // Number of register stages from input to output register
  localparam int unsigned NumStages = 7;

  // Hue sector, one sixth of a turn each
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

  // Per-stage load enables, driven by the pipeline control in the top level
  typedef struct packed {
    logic s7;
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } stage_en_t;

endpackage

// ===== sv/hsv2rgb_sector.sv =====
// First pipeline stage: hue sector and fraction, inverse saturation.
// Depends on hsv2rgb_pkg.
module hsv2rgb_sector #(
  parameter int unsigned HUE_BITS     = 12,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                          clk_i,
  input  hsv2rgb_pkg::stage_en_t        en_i,
  input  logic [HUE_BITS-1:0]           hue_i,
  input  logic [CHANNEL_BITS-1:0]       saturation_i,
  input  logic [CHANNEL_BITS-1:0]       brightness_i,
  input  logic [CHANNEL_BITS-1:0]       alpha_i,
  output hsv2rgb_pkg::sector_e          sector_o,
  output logic [HUE_BITS-1:0]           frac_o,
  output logic [CHANNEL_BITS-1:0]       saturation_o,
  output logic [CHANNEL_BITS-1:0]       inv_sat_o,
  output logic [CHANNEL_BITS-1:0]       brightness_o,
  output logic [CHANNEL_BITS-1:0]       alpha_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned H = HUE_BITS;
  localparam int unsigned C = CHANNEL_BITS;
  localparam logic [C-1:0] ChMax = '1;

  logic [H+2:0] six_h;
  logic [H+2:0] hue_ext;

  sector_e      sector_q;
  logic [H-1:0] frac_q;
  logic [C-1:0] sat_q, inv_sat_q, bri_q, alpha_q;

  // 6h = 4h + 2h; top three bits are the sector, the rest the fraction
  assign hue_ext = (H+3)'(hue_i);
  assign six_h   = (hue_ext << 2) + (hue_ext << 1);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      sector_q  <= sector_e'(six_h[H+2:H]);
      frac_q    <= six_h[H-1:0];
      sat_q     <= saturation_i;
      inv_sat_q <= ChMax - saturation_i;
      bri_q     <= brightness_i;
      alpha_q   <= alpha_i;
    end
  end

  assign sector_o     = sector_q;
  assign frac_o       = frac_q;
  assign saturation_o = sat_q;
  assign inv_sat_o    = inv_sat_q;
  assign brightness_o = bri_q;
  assign alpha_o      = alpha_q;

endmodule

// ===== sv/hsv2rgb_level.sv =====
// Stages two to six: products and rounded divides giving the levels p, q and t.
// Depends on hsv2rgb_pkg.
module hsv2rgb_level #(
  parameter int unsigned HUE_BITS     = 12,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                          clk_i,
  input  hsv2rgb_pkg::stage_en_t        en_i,
  input  hsv2rgb_pkg::sector_e          sector_i,
  input  logic [HUE_BITS-1:0]           frac_i,
  input  logic [CHANNEL_BITS-1:0]       saturation_i,
  input  logic [CHANNEL_BITS-1:0]       inv_sat_i,
  input  logic [CHANNEL_BITS-1:0]       brightness_i,
  input  logic [CHANNEL_BITS-1:0]       alpha_i,
  output hsv2rgb_pkg::sector_e          sector_o,
  output logic [CHANNEL_BITS-1:0]       brightness_o,
  output logic [CHANNEL_BITS-1:0]       alpha_o,
  output logic [CHANNEL_BITS-1:0]       p_o,
  output logic [CHANNEL_BITS-1:0]       q_o,
  output logic [CHANNEL_BITS-1:0]       t_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned H  = HUE_BITS;
  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned PW = 2 * C;       // p product and quotient input width
  localparam int unsigned XW = 2 * C + H;   // q/t product width

  localparam logic [C-1:0]   ChMax    = '1;
  localparam logic [H:0]     HueMod   = {1'b1, {H{1'b0}}};
  localparam logic [C+H-1:0] FullDen  = {ChMax, {H{1'b0}}};
  localparam logic [PW-1:0]  HalfMax  = PW'({(C-1){1'b1}});
  localparam logic [XW-1:0]  HalfFull = XW'({ChMax, {(H-1){1'b0}}});

  // floor(z / (2^C - 1)) for z < 2^(2C) with quotient below 2^C
  function automatic logic [C-1:0] div_max(input logic [PW-1:0] z);
    logic [PW-1:0] sum;
    sum = z + (z >> C) + PW'(1);
    return sum[PW-1:C];
  endfunction

  // stage two
  logic [C+H-1:0] fs_q_q, fs_t_q;
  logic [H:0]     hm_f;
  logic [C+H:0]   fs_t_full;
  logic [PW-1:0]  pp_q;
  // stage three
  logic [C+H-1:0] nq_q, nt_q;
  logic [PW-1:0]  zp_q;
  // stage four
  logic [XW-1:0]  xq_q, xt_q;
  logic [C-1:0]   p4_q;
  // stage five
  logic [XW-1:0]  sq, st;
  logic [PW-1:0]  zq_q, zt_q;
  logic [C-1:0]   p5_q;
  // stage six
  logic [C-1:0]   p6_q, q6_q, t6_q;

  // sideband carried alongside, one register per stage
  sector_e      sec_q [2:6];
  logic [C-1:0] bri_q [2:6];
  logic [C-1:0] alp_q [2:6];

  assign hm_f      = HueMod - (H+1)'(frac_i);
  assign fs_t_full = (C+H+1)'(hm_f) * (C+H+1)'(saturation_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      fs_q_q   <= (C+H)'(frac_i) * (C+H)'(saturation_i);
      fs_t_q   <= fs_t_full[C+H-1:0];
      pp_q     <= PW'(brightness_i) * PW'(inv_sat_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      nq_q     <= FullDen - fs_q_q;
      nt_q     <= FullDen - fs_t_q;
      zp_q     <= pp_q + HalfMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      xq_q     <= XW'(bri_q[3]) * XW'(nq_q);
      xt_q     <= XW'(bri_q[3]) * XW'(nt_q);
      p4_q     <= div_max(zp_q);
    end
  end

  // add half the denominator, then drop the power-of-two part of it
  assign sq = xq_q + HalfFull;
  assign st = xt_q + HalfFull;

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      zq_q     <= sq[XW-1:H];
      zt_q     <= st[XW-1:H];
      p5_q     <= p4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      q6_q     <= div_max(zq_q);
      t6_q     <= div_max(zt_q);
      p6_q     <= p5_q;
    end
  end

  // advance sector, value and alpha with their stage
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sec_q[2] <= sector_i;
      bri_q[2] <= brightness_i;
      alp_q[2] <= alpha_i;
    end
    if (en_i.s3) begin
      sec_q[3] <= sec_q[2];
      bri_q[3] <= bri_q[2];
      alp_q[3] <= alp_q[2];
    end
    if (en_i.s4) begin
      sec_q[4] <= sec_q[3];
      bri_q[4] <= bri_q[3];
      alp_q[4] <= alp_q[3];
    end
    if (en_i.s5) begin
      sec_q[5] <= sec_q[4];
      bri_q[5] <= bri_q[4];
      alp_q[5] <= alp_q[4];
    end
    if (en_i.s6) begin
      sec_q[6] <= sec_q[5];
      bri_q[6] <= bri_q[5];
      alp_q[6] <= alp_q[5];
    end
  end

  assign sector_o     = sec_q[6];
  assign brightness_o = bri_q[6];
  assign alpha_o      = alp_q[6];
  assign p_o          = p6_q;
  assign q_o          = q6_q;
  assign t_o          = t6_q;

endmodule

// ===== sv/hsv_to_rgb.sv =====
// Seven register stages, each with its own valid bit, carry an item to the master side.
// Throughput: one item per cycle while the master side keeps taking items.
// A stalled stage holds its item and only the stages behind it stop; bubbles close up.
// Reset (rst_ni low, asynchronous) empties every stage; payload registers keep old data.
// Depends on hsv2rgb_pkg, hsv2rgb_sector and hsv2rgb_level.
module hsv_to_rgb #(
  parameter int unsigned HUE_BITS     = 12,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // slave side: hue, saturation, brightness, alpha_in (lowest bits first), zero pad
  input  logic                                                 s_axis_tvalid_i,
  output logic                                                 s_axis_tready_o,
  input  logic [((HUE_BITS+3*CHANNEL_BITS+7)/8)*8-1:0]         s_axis_tdata_i,
  // master side: red, green, blue, alpha_out (lowest bits first), zero pad
  output logic                                                 m_axis_tvalid_o,
  input  logic                                                 m_axis_tready_i,
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]                  m_axis_tdata_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned H    = HUE_BITS;
  localparam int unsigned C    = CHANNEL_BITS;
  localparam int unsigned OutW = ((4*C+7)/8)*8;

  // unpack the slave item
  logic [H-1:0] in_hue;
  logic [C-1:0] in_sat, in_bri, in_alpha;

  assign in_hue   = s_axis_tdata_i[H-1:0];
  assign in_sat   = s_axis_tdata_i[H+C-1:H];
  assign in_bri   = s_axis_tdata_i[H+2*C-1:H+C];
  assign in_alpha = s_axis_tdata_i[H+3*C-1:H+2*C];

  // ------------------------------------------------------------------
  // Pipeline control. Stage k (index k-1) may load when it is empty or
  // when the stage after it loads this cycle; the last stage frees up
  // when the master side takes its item.
  // ------------------------------------------------------------------
  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] load;
  stage_en_t            en;

  always_comb begin
    load[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    // stage one fills from the slave side, the rest from the stage before
    if (load[0]) begin
      valid_d[0] = s_axis_tvalid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en = stage_en_t'(load);

  assign s_axis_tready_o = load[0];

  // ------------------------------------------------------------------
  // Stage one: sector, fraction within the sector, 2^C-1 minus S
  // ------------------------------------------------------------------
  sector_e      s1_sector;
  logic [H-1:0] s1_frac;
  logic [C-1:0] s1_sat, s1_inv_sat, s1_bri, s1_alpha;

  hsv2rgb_sector #(
    .HUE_BITS     (H),
    .CHANNEL_BITS (C)
  ) u_sector (
    .clk_i        (clk_i),
    .en_i         (en),
    .hue_i        (in_hue),
    .saturation_i (in_sat),
    .brightness_i (in_bri),
    .alpha_i      (in_alpha),
    .sector_o     (s1_sector),
    .frac_o       (s1_frac),
    .saturation_o (s1_sat),
    .inv_sat_o    (s1_inv_sat),
    .brightness_o (s1_bri),
    .alpha_o      (s1_alpha)
  );

  // ------------------------------------------------------------------
  // Stages two to six: levels p, q, t, each rounded to nearest, ties up
  // ------------------------------------------------------------------
  sector_e      s6_sector;
  logic [C-1:0] s6_bri, s6_alpha, s6_p, s6_q, s6_t;

  hsv2rgb_level #(
    .HUE_BITS     (H),
    .CHANNEL_BITS (C)
  ) u_level (
    .clk_i        (clk_i),
    .en_i         (en),
    .sector_i     (s1_sector),
    .frac_i       (s1_frac),
    .saturation_i (s1_sat),
    .inv_sat_i    (s1_inv_sat),
    .brightness_i (s1_bri),
    .alpha_i      (s1_alpha),
    .sector_o     (s6_sector),
    .brightness_o (s6_bri),
    .alpha_o      (s6_alpha),
    .p_o          (s6_p),
    .q_o          (s6_q),
    .t_o          (s6_t)
  );

  // ------------------------------------------------------------------
  // Stage seven: six-way sector mux into the output register
  // ------------------------------------------------------------------
  logic [C-1:0] red_d, green_d, blue_d;
  logic [C-1:0] red_q, green_q, blue_q, alpha_q;

  always_comb begin
    unique case (s6_sector)
      SEC_0: begin
        red_d = s6_bri; green_d = s6_t;   blue_d = s6_p;
      end
      SEC_1: begin
        red_d = s6_q;   green_d = s6_bri; blue_d = s6_p;
      end
      SEC_2: begin
        red_d = s6_p;   green_d = s6_bri; blue_d = s6_t;
      end
      SEC_3: begin
        red_d = s6_p;   green_d = s6_q;   blue_d = s6_bri;
      end
      SEC_4: begin
        red_d = s6_t;   green_d = s6_p;   blue_d = s6_bri;
      end
      SEC_5: begin
        red_d = s6_bri; green_d = s6_p;   blue_d = s6_q;
      end
      default: begin
        // codes above five never arise from the sector stage
        red_d = '0;     green_d = '0;     blue_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en.s7) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= s6_alpha;
    end
  end

  assign m_axis_tvalid_o = valid_q[NumStages-1];
  assign m_axis_tdata_o  = OutW'({alpha_q, blue_q, green_q, red_q});

`ifndef SYNTH
  // an empty or draining output stage frees the whole pipe for a new item
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("slave side stalled while the output stage was free");

  // a result only appears after passing through stage six
  a_out_from_stage6: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(valid_q[NumStages-2]))
    else $error("output became valid without an item in stage six");

  // a stalled result keeps its colour
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");
`endif

endmodule

// ===== verif/hsv_to_rgb_checker.sv =====
// Checker for the hsv_to_rgb colour converter: watches both stream channels,
// predicts each RGBA item from the accepted HSVA item and compares in order.
// Depends on hsv2rgb_pkg for the sector codes.
module hsv_to_rgb_checker #(
  parameter int unsigned HUE_BITS     = 12,
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned SDataW       = 40,
  parameter int unsigned MDataW       = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [SDataW-1:0] s_axis_tdata_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [MDataW-1:0] m_axis_tdata_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS;

  typedef struct packed {
    logic [CB-1:0] alpha;
    logic [CB-1:0] blue;
    logic [CB-1:0] green;
    logic [CB-1:0] red;
  } rgba_t;

  rgba_t rgba_due_q[$];

  // nearest integer, ties up
  function automatic longint unsigned round_half_up(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic rgba_t hsv_pixel_to_rgba(logic [HUE_BITS-1:0] hue, logic [CB-1:0] sat,
                                              logic [CB-1:0] bri, logic [CB-1:0] alp);
    longint unsigned hue_mod, ch_max, full_den, v, s, six_h, frac, lvl_p, lvl_q, lvl_t;
    sector_e sector;
    rgba_t px;
    hue_mod  = 64'd1 << HUE_BITS;
    ch_max   = (64'd1 << CB) - 1;
    full_den = ch_max * hue_mod;
    v        = 64'(bri);
    s        = 64'(sat);
    six_h    = 6 * 64'(hue);
    sector   = sector_e'(six_h[HUE_BITS+2:HUE_BITS]);
    frac     = six_h & (hue_mod - 1);
    lvl_p    = round_half_up(v * (ch_max - s), ch_max);
    lvl_q    = round_half_up(v * (full_den - frac * s), full_den);
    lvl_t    = round_half_up(v * (full_den - (hue_mod - frac) * s), full_den);
    px.alpha = alp;
    unique case (sector)
      SEC_0: begin px.red = CB'(v);     px.green = CB'(lvl_t); px.blue = CB'(lvl_p); end
      SEC_1: begin px.red = CB'(lvl_q); px.green = CB'(v);     px.blue = CB'(lvl_p); end
      SEC_2: begin px.red = CB'(lvl_p); px.green = CB'(v);     px.blue = CB'(lvl_t); end
      SEC_3: begin px.red = CB'(lvl_p); px.green = CB'(lvl_q); px.blue = CB'(v);     end
      SEC_4: begin px.red = CB'(lvl_t); px.green = CB'(lvl_p); px.blue = CB'(v);     end
      SEC_5: begin px.red = CB'(v);     px.green = CB'(lvl_p); px.blue = CB'(lvl_q); end
      default: begin px.red = '0;       px.green = '0;         px.blue = '0;         end
    endcase
    return px;
  endfunction

  always @(posedge clk_i) begin
    rgba_t seen, due;
    int unsigned bad;
    bad = 0;
    if (!rst_ni) begin
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // compare first so an item entering this cycle never meets its own result
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen = rgba_t'(m_axis_tdata_i[4*CB-1:0]);
        if (rgba_due_q.size() == 0) begin
          $error("unexpected item on master side: %h", seen);
          bad++;
        end else begin
          due = rgba_due_q.pop_front();
          if (seen.red !== due.red) begin
            $error("red: expected %0d, actual %0d", due.red, seen.red);
            bad++;
          end
          if (seen.green !== due.green) begin
            $error("green: expected %0d, actual %0d", due.green, seen.green);
            bad++;
          end
          if (seen.blue !== due.blue) begin
            $error("blue: expected %0d, actual %0d", due.blue, seen.blue);
            bad++;
          end
          if (seen.alpha !== due.alpha) begin
            $error("alpha_out: expected %0d, actual %0d", due.alpha, seen.alpha);
            bad++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        rgba_due_q.push_back(hsv_pixel_to_rgba(
          s_axis_tdata_i[HUE_BITS-1:0],
          s_axis_tdata_i[HUE_BITS +: CB],
          s_axis_tdata_i[HUE_BITS+CB +: CB],
          s_axis_tdata_i[HUE_BITS+2*CB +: CB]));
      errors_o  <= errors_o + bad;
      pending_o <= unsigned'(rgba_due_q.size());
    end
  end

endmodule

// ===== verif/tb.sv =====
// Top of the hsv_to_rgb testbench: clock, reset, item stimulus, output back-pressure
// and the verdict. Depends on hsv2rgb_pkg, hsv_to_rgb and hsv_to_rgb_checker.
module tb;
  import hsv2rgb_pkg::*;

  localparam int unsigned HUE_BITS     = 12;
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned SDataW = ((HUE_BITS + 3 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int unsigned MDataW = ((4 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int unsigned RandomPixels = 500;
  // the watchdog limit covers the slowest legal run of 520 items with the longest gaps and stalls
  localparam int unsigned CycleLimit = 200000;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [SDataW-1:0] s_axis_tdata_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [MDataW-1:0] m_axis_tdata_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles;

  // handshake flags, latched at the falling edge so the rising edge reads them race-free
  logic pixel_in_taken;
  logic pixel_out_taken;

  hsv_to_rgb #(
    .HUE_BITS    (HUE_BITS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  hsv_to_rgb_checker #(
    .HUE_BITS    (HUE_BITS),
    .CHANNEL_BITS(CHANNEL_BITS),
    .SDataW      (SDataW),
    .MDataW      (MDataW)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    pixel_in_taken  = s_axis_tvalid_i && s_axis_tready_o;
    pixel_out_taken = m_axis_tvalid_o && m_axis_tready_i;
  end

  // Watchdog: a hung pipeline ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sender side: steady phases send back to back, otherwise draw a random gap before each item.
  bit steady_send;

  task automatic send_pixel(logic [HUE_BITS-1:0] hue, logic [CHANNEL_BITS-1:0] sat,
                            logic [CHANNEL_BITS-1:0] bri, logic [CHANNEL_BITS-1:0] alp);
    int unsigned gap;
    gap = steady_send ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // pack from the lowest bit: hue, saturation, brightness, alpha, zero pad
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= SDataW'({alp, bri, sat, hue});
    @(posedge clk_i);
    while (!pixel_in_taken) @(posedge clk_i);
  endtask

  // Bias a channel towards its ends now and then; the rest stays uniform.
  function automatic logic [CHANNEL_BITS-1:0] draw_channel();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return CHANNEL_BITS'($urandom);
  endfunction

  // Receiver side: hold tready low for a drawn stall before each result, with
  // stall-free stretches mixed in.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit steady_recv;
    m_axis_tready_i <= 1'b0;
    steady_recv = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 64 == 0) steady_recv = ($urandom_range(0, 2) == 0);
      stall = steady_recv ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!pixel_out_taken) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    logic [HUE_BITS-1:0] edge_hues[12];
    logic [HUE_BITS-1:0] hue;
    int unsigned i;

    // sector boundaries from both sides, plus both ends of the hue range
    edge_hues = '{12'd0, 12'd682, 12'd683, 12'd1365, 12'd1366, 12'd2047,
                  12'd2048, 12'd2730, 12'd2731, 12'd3413, 12'd3414, 12'd4095};

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    steady_send     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every sector at full saturation and value, then grey, black and odd levels.
    foreach (edge_hues[k]) send_pixel(edge_hues[k], '1, '1, CHANNEL_BITS'($urandom));
    send_pixel(12'd1000, '0, 8'd200, '0);
    send_pixel(12'd3000, '1, '0, '1);
    send_pixel('1, '0, '0, '0);
    send_pixel('0, '0, '1, '1);
    send_pixel(12'd1234, 8'd128, 8'd127, 8'd170);
    send_pixel(12'd2222, 8'd1, 8'd1, 8'd85);
    send_pixel(12'd3500, 8'd254, 8'd254, 8'd1);
    send_pixel(12'd600, 8'd1, 8'd255, 8'd254);

    // Random items; switch between gapped and back-to-back phases every 64.
    for (i = 0; i < RandomPixels; i++) begin
      if (i % 64 == 0) steady_send = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 7) == 0)
        hue = edge_hues[$urandom_range(0, 11)];
      else
        hue = HUE_BITS'($urandom);
      send_pixel(hue, draw_channel(), draw_channel(), CHANNEL_BITS'($urandom));
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain: wait for every predicted item, then a few pipeline depths for strays.
    while (pending != 0) @(posedge clk_i);
    repeat (3 * NumStages + 10) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
